// ===== hw/rtl/mtr_pkg.sv =====
`timescale 1ns / 1ps

package mtr_pkg;

  // twister geometry
  localparam int unsigned N     = 624;
  localparam int unsigned M     = 397;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 10;

  // constants of the generator
  localparam logic [31:0] TWIST_XOR     = 32'h9908b0df;
  localparam logic [31:0] TOP_BIT_MASK  = 32'h80000000;
  localparam logic [31:0] LOW_BITS_MASK = 32'h7fffffff;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] LIN_SEED   = 32'd19650218;
  localparam logic [31:0] MIX1_MULT  = 32'd1664525;
  localparam logic [31:0] MIX2_MULT  = 32'd1566083941;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc60000;

  // stream payload widths
  localparam int unsigned IN_W  = 80;
  localparam int unsigned OUT_W = 72;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_BITS   = 2'd1,
    OP_BELOW  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_K    = 2'd1,
    ST_ZERO     = 2'd2,
    ST_UNSEEDED = 2'd3
  } status_e;

  // datapath micro-operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_EVAL,
    DP_FILL0,
    DP_FILL_A,
    DP_FILL_B,
    DP_MIX_INIT,
    DP_MIX1_A,
    DP_MIX1_B,
    DP_MIX2_INIT,
    DP_MIX2_A,
    DP_MIX2_B,
    DP_FIN,
    DP_BLEN1,
    DP_BLEN2,
    DP_RD,
    DP_WORD,
    DP_DRAW,
    DP_TW0,
    DP_TW_CUR,
    DP_TW_A,
    DP_TW_B,
    DP_TW_C,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    op_e              op;
    logic             err;
    logic             pos_last;
    logic             cnt_zero;
    logic             widx_full;
    logic             need2;
    logic             below;
    logic [IDX_W-1:0] widx;
  } dp_sts_t;

  function automatic logic [31:0] mix_prev(input logic [31:0] v);
    return v ^ (v >> 30);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // index of the highest set bit of a byte
  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/mtr_ram.sv =====
`timescale 1ns / 1ps

module mtr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/mtr_dp.sv =====
`timescale 1ns / 1ps

module mtr_dp import mtr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_wen_i,
  input  logic [63:0]     cfg_wdata_i,
  input  logic [IN_W-1:0] in_data_i,
  input  dp_cmd_t         cmd_i,
  output dp_sts_t         sts_o,
  output logic [OUT_W-1:0] out_data_o
);

  logic [63:0]      seed_q;
  logic             seeded_q;
  logic [IDX_W-1:0] widx_q;

  op_e              op_q;
  logic [6:0]       k_q;
  logic [63:0]      bound_q;
  logic [IDX_W-1:0] pos_q;
  logic [CNT_W-1:0] cnt_q;
  logic             j_q;
  logic [31:0]      prev_q, prod_q, cur_q, nxt_q;
  logic [63:0]      acc_q;
  status_e          stat_q;
  logic [1:0]       wc_q;
  logic [7:0]       bnz_q;
  logic [2:0]       bpos_q [8];
  logic [OUT_W-1:0] out_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  logic [IDX_W-1:0] nxt_pos, far_pos, wrap_pos;
  logic [31:0]      key_j, tw_y, tw_val, tword, tshift;
  logic [6:0]       sh, blen;
  status_e          err_code;

  mtr_ram #(.WIDTH(32), .DEPTH(N)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign nxt_pos  = (pos_q == IDX_W'(N - 1)) ? '0 : pos_q + IDX_W'(1);
  assign wrap_pos = (pos_q == IDX_W'(N - 1)) ? IDX_W'(1) : pos_q + IDX_W'(1);
  assign far_pos  = (pos_q >= IDX_W'(N - M)) ? pos_q - IDX_W'(N - M) : pos_q + IDX_W'(M);

  assign key_j  = (j_q ? seed_q[63:32] : seed_q[31:0]) + {31'd0, j_q};
  assign tw_y   = (cur_q & TOP_BIT_MASK) | (nxt_q & LOW_BITS_MASK);
  assign tw_val = ram_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_XOR : 32'd0);

  assign tword  = temper(ram_rdata);
  assign sh     = (k_q <= 7'd32) ? 7'd32 - k_q : 7'd64 - k_q;
  assign tshift = tword >> sh[4:0];

  always_comb begin
    err_code = ST_OK;
    if (op_q == OP_BITS) begin
      if (k_q == 7'd0 || k_q > 7'd64) err_code = ST_BAD_K;
      else if (!seeded_q)             err_code = ST_UNSEEDED;
    end else if (op_q == OP_BELOW) begin
      if (bound_q == 64'd0) err_code = ST_ZERO;
      else if (!seeded_q)   err_code = ST_UNSEEDED;
    end
  end

  // highest nonzero byte wins
  always_comb begin
    blen = 7'd0;
    for (int b = 0; b < 8; b++) begin
      if (bnz_q[b]) blen = {1'b0, 3'(b), bpos_q[b]} + 7'd1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = 32'd0;
    ram_raddr = pos_q;
    unique case (cmd_i.op)
      DP_FILL_B: begin
        ram_we    = 1'b1;
        ram_wdata = prod_q + 32'(pos_q);
      end
      DP_MIX1_B: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata ^ prod_q) + key_j;
      end
      DP_MIX2_B: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata ^ prod_q) - 32'(pos_q);
      end
      DP_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = TOP_BIT_MASK;
      end
      DP_TW0:  ram_raddr = '0;
      DP_TW_A: ram_raddr = nxt_pos;
      DP_TW_B: ram_raddr = far_pos;
      DP_TW_C: begin
        ram_we    = 1'b1;
        ram_wdata = tw_val;
      end
      DP_RD:   ram_raddr = widx_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= 64'd0;
      seeded_q <= 1'b0;
      widx_q   <= IDX_W'(N);
    end else begin
      if (cfg_wen_i) seed_q <= cfg_wdata_i;
      unique case (cmd_i.op)
        DP_FIN: begin
          seeded_q <= 1'b1;
          widx_q   <= IDX_W'(N);
        end
        DP_WORD: widx_q <= widx_q + IDX_W'(1);
        DP_TW_C: if (pos_q == IDX_W'(N - 1)) widx_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        op_q    <= op_e'(in_data_i[1:0]);
        k_q     <= in_data_i[8:2];
        bound_q <= in_data_i[72:9];
      end
      DP_EVAL: begin
        acc_q  <= 64'd0;
        stat_q <= err_code;
        wc_q   <= 2'd0;
      end
      DP_FILL0: begin
        prev_q <= LIN_SEED;
        pos_q  <= IDX_W'(1);
      end
      DP_FILL_A: prod_q <= mix_prev(prev_q) * INIT_MULT;
      DP_FILL_B: begin
        prev_q <= ram_wdata;
        pos_q  <= pos_q + IDX_W'(1);
      end
      DP_MIX_INIT: begin
        prev_q <= LIN_SEED;
        pos_q  <= IDX_W'(1);
        j_q    <= 1'b0;
        cnt_q  <= CNT_W'(N - 1);
      end
      DP_MIX1_A: prod_q <= mix_prev(prev_q) * MIX1_MULT;
      DP_MIX1_B: begin
        prev_q <= ram_wdata;
        pos_q  <= wrap_pos;
        j_q    <= (seed_q[63:32] != 32'd0) ? ~j_q : 1'b0;
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      DP_MIX2_INIT: cnt_q <= CNT_W'(N - 2);
      DP_MIX2_A: prod_q <= mix_prev(prev_q) * MIX2_MULT;
      DP_MIX2_B: begin
        prev_q <= ram_wdata;
        pos_q  <= wrap_pos;
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      DP_BLEN1: begin
        for (int b = 0; b < 8; b++) begin
          bnz_q[b]  <= |bound_q[8*b +: 8];
          bpos_q[b] <= msb8(bound_q[8*b +: 8]);
        end
      end
      DP_BLEN2: k_q <= blen;
      DP_WORD: begin
        wc_q <= wc_q + 2'd1;
        if (k_q <= 7'd32)       acc_q <= {32'd0, tshift};
        else if (wc_q == 2'd0)  acc_q <= {32'd0, tword};
        else                    acc_q[63:32] <= tshift;
      end
      DP_DRAW: wc_q <= 2'd0;
      DP_TW0:  pos_q <= '0;
      DP_TW_CUR: cur_q <= ram_rdata;
      DP_TW_B: nxt_q <= ram_rdata;
      DP_TW_C: begin
        cur_q <= nxt_q;
        pos_q <= pos_q + IDX_W'(1);
      end
      DP_OUT: out_q <= {6'd0, stat_q, acc_q};
      default: ;
    endcase
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.err       = (err_code != ST_OK);
    sts_o.pos_last  = (pos_q == IDX_W'(N - 1));
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.widx_full = (widx_q == IDX_W'(N));
    sts_o.need2     = (k_q > 7'd32) && (wc_q == 2'd0);
    sts_o.below     = (acc_q < bound_q);
    sts_o.widx      = widx_q;
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/mtr_ctrl.sv =====
`timescale 1ns / 1ps

module mtr_ctrl import mtr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_EVAL, S_FILL0, S_FILL_A, S_FILL_B, S_MIX_INIT, S_MIX1_A, S_MIX1_B,
    S_MIX2_INIT, S_MIX2_A, S_MIX2_B, S_FIN, S_BLEN1, S_BLEN2, S_WCHK, S_WORD,
    S_DECIDE, S_TW0, S_TW_CUR, S_TW_A, S_TW_B, S_TW_C, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, valid_q;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NOP;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = DP_LOAD;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.op = DP_EVAL;
        if (sts_i.op == OP_RESEED)                  state_d = S_FILL0;
        else if (sts_i.op == OP_BITS && !sts_i.err) state_d = S_WCHK;
        else if (sts_i.op == OP_BELOW && !sts_i.err) state_d = S_BLEN1;
        else                                        state_d = S_RESULT;
      end
      S_FILL0:  begin cmd_o.op = DP_FILL0;  state_d = S_FILL_A; end
      S_FILL_A: begin cmd_o.op = DP_FILL_A; state_d = S_FILL_B; end
      S_FILL_B: begin
        cmd_o.op = DP_FILL_B;
        state_d  = sts_i.pos_last ? S_MIX_INIT : S_FILL_A;
      end
      S_MIX_INIT: begin cmd_o.op = DP_MIX_INIT; state_d = S_MIX1_A; end
      S_MIX1_A:   begin cmd_o.op = DP_MIX1_A;   state_d = S_MIX1_B; end
      S_MIX1_B: begin
        cmd_o.op = DP_MIX1_B;
        state_d  = sts_i.cnt_zero ? S_MIX2_INIT : S_MIX1_A;
      end
      S_MIX2_INIT: begin cmd_o.op = DP_MIX2_INIT; state_d = S_MIX2_A; end
      S_MIX2_A:    begin cmd_o.op = DP_MIX2_A;    state_d = S_MIX2_B; end
      S_MIX2_B: begin
        cmd_o.op = DP_MIX2_B;
        state_d  = sts_i.cnt_zero ? S_FIN : S_MIX2_A;
      end
      S_FIN:   begin cmd_o.op = DP_FIN;   state_d = S_RESULT; end
      S_BLEN1: begin cmd_o.op = DP_BLEN1; state_d = S_BLEN2; end
      S_BLEN2: begin cmd_o.op = DP_BLEN2; state_d = S_WCHK; end
      S_WCHK: begin
        if (sts_i.widx_full) begin
          state_d = S_TW0;
        end else begin
          cmd_o.op = DP_RD;
          state_d  = S_WORD;
        end
      end
      S_WORD: begin
        cmd_o.op = DP_WORD;
        if (sts_i.need2)                 state_d = S_WCHK;
        else if (sts_i.op == OP_BELOW)   state_d = S_DECIDE;
        else                             state_d = S_RESULT;
      end
      S_DECIDE: begin
        if (sts_i.below) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.op = DP_DRAW;
          state_d  = S_WCHK;
        end
      end
      S_TW0:    begin cmd_o.op = DP_TW0;    state_d = S_TW_CUR; end
      S_TW_CUR: begin cmd_o.op = DP_TW_CUR; state_d = S_TW_A; end
      S_TW_A:   begin cmd_o.op = DP_TW_A;   state_d = S_TW_B; end
      S_TW_B:   begin cmd_o.op = DP_TW_B;   state_d = S_TW_C; end
      S_TW_C: begin
        cmd_o.op = DP_TW_C;
        state_d  = sts_i.pos_last ? S_WCHK : S_TW_A;
      end
      S_RESULT: if (!valid_q || out_ready_i) begin
        cmd_o.op = DP_OUT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
      if (cmd_o.op == DP_OUT) valid_q <= 1'b1;
      else if (out_ready_i)   valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;

endmodule

// ===== hw/rtl/mt19937_random_bits_top.sv =====
`timescale 1ns / 1ps
// sequence: a draw of up to 32 bits reads and tempers one word, a draw above 32 bits two;
// random-below first finds the bound's bit length, then redraws until a draw is below the bound
// throughput: one transaction at a time, the next taken the cycle after the result loads
// all 624 words are refilled when a draw finds them used up; a reseed fills and mixes them
// reset: asynchronous, active low; seed clears to zero, block unseeded, word index 624
// the word memory is not cleared: the first reseed defines it
module mt19937_random_bits_top import mtr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // seed register write
  input  logic             cfg_wen_i,
  input  logic [63:0]      cfg_wdata_i,
  // request stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // operation[1:0], bit_count[8:2], upper_bound[72:9]
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // value[63:0], status[65:64]
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: decodes the request and steps through seeding, refill and draws
  mtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // datapath: word memory, multipliers, tempering and the result register
  mtr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_data_o  (m_axis_tdata)
  );

  // a transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // the word index never runs past the state size
  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_sts.widx <= IDX_W'(N))
    else $error("word index out of range");

  // a word read only happens with words left, never before a refill
  a_read_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.op == DP_RD |-> !dp_sts.widx_full)
    else $error("word read with exhausted state");

endmodule
